### rtl/hpwl_pkg.sv
// ----------------------------------------------------------------------------
// hpwl_pkg
// shared widths and constants of the histogram white level block
// ----------------------------------------------------------------------------
`default_nettype none

package hpwl_pkg;

   // default bin count of the histogram
   localparam int BINS_DEFAULT = 256;

   // pixel and result field widths
   localparam int CHAN_W  = 8;
   localparam int LEVEL_W = 9;

   // bin counts and pixel count
   localparam int CNT_W = 32;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // colour channels counted per pixel
   localparam int NUM_CH = 3;

   // percentile as a ratio
   localparam int PCT_NUM = 99;
   localparam int PCT_DEN = 100;
   localparam int PCT_NUM_W = 9;                   // holds NUM_CH * PCT_NUM
   localparam int PCT_DEN_W = 7;                   // holds PCT_DEN
   localparam int CH_PCT = NUM_CH * PCT_NUM;

   // full scale of a channel byte
   localparam int BYTE_MAX = 8'hff;

endpackage

`default_nettype wire

### rtl/hpwl_if.sv
// ----------------------------------------------------------------------------
// hpwl_req_if / hpwl_rsp_if
// pixel and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface hpwl_req_if import hpwl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              last_pixel;

   modport source (output valid, output red, output green, output blue,
                   output last_pixel, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input last_pixel, output ready);
endinterface

interface hpwl_rsp_if import hpwl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] white_bin;
   logic               count_saturated;

   modport source (output valid, output white_bin, output count_saturated,
                   input ready);
   modport sink   (input valid, input white_bin, input count_saturated,
                   output ready);
endinterface

`default_nettype wire

### rtl/hpwl_ram.sv
// ----------------------------------------------------------------------------
// hpwl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hpwl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/histogram_percentile_white_level_core.sv
// ----------------------------------------------------------------------------
// histogram_percentile_white_level_core
// per-frame rgb histogram and 99th percentile white level
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                         transfer
//  req_chan  in   red, green, blue, last_pixel    one pixel
//  rsp_chan  out  white_bin, count_saturated      one level per frame
//
//  a pixel takes its transfer plus three read-modify-write passes through
//  the one histogram ram, the last write overlapping the next transfer
//  after a last pixel come its last write, a scan of every bin, which also
//  zeroes each bin, a drain of the summing pipeline and the load of the
//  output register
//  after reset a zeroing pass over every bin runs before the first transfer
//  a result waits in its output register; a new frame end stalls only if the
//  previous result is still untaken
//
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_percentile_white_level_core import hpwl_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hpwl_req_if.sink    req_chan,
   hpwl_rsp_if.source  rsp_chan
);

   localparam int BIN_W  = $clog2(BINS);
   localparam int LVL_W  = $clog2(BINS + 1);
   localparam int PROD_W = CHAN_W + LVL_W;          // byte * BINS
   localparam int MUL_W  = PROD_W + 9;              // byte * BINS * 257
   localparam int P_W    = CNT_W + PCT_NUM_W;       // pixel count * 297
   localparam int HUND_W = CNT_W + PCT_DEN_W;       // bin count * 100
   localparam int ACC_W  = HUND_W + BIN_W;          // running sum * 100

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD,
      ST_FLUSH,
      ST_SCAN,
      ST_TAIL,
      ST_EMIT
   } state_type;

   // bin of one channel byte: floor(b * BINS / 255) clipped to BINS - 1
   // the quotient comes from x * 257 >> 16, low by at most one, then corrected
   function automatic logic [BIN_W-1:0] bin_of(input logic [CHAN_W-1:0] b);
      logic [PROD_W-1:0] x;
      logic [MUL_W-1:0]  t;
      logic [LVL_W-1:0]  q;
      logic [PROD_W-1:0] r;
      x = PROD_W'(b) * PROD_W'(BINS);
      t = MUL_W'(x) + (MUL_W'(x) << 8);
      q = LVL_W'(t >> 16);
      r = x - ((PROD_W'(q) << 8) - PROD_W'(q));
      if (r >= PROD_W'(BYTE_MAX)) begin
         q = q + LVL_W'(1);
      end
      if (q > LVL_W'(BINS - 1)) begin
         return BIN_W'(BINS - 1);
      end
      return BIN_W'(q);
   endfunction

   // control state
   state_type          state_ff, state_in;
   logic [BIN_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         ch_ff, ch_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   pix_ff, pix_in;
   logic               sat_ff, sat_in;

   // latched bins of the pixel being counted
   logic [BIN_W-1:0]   bin_ff [NUM_CH];
   logic [BIN_W-1:0]   bin_in [NUM_CH];

   // write-back stage and last-write forwarding
   logic               w_val_ff, w_val_in;
   logic [BIN_W-1:0]   w_addr_ff, w_addr_in;
   logic               lw_val_ff, lw_val_in;
   logic [BIN_W-1:0]   lw_addr_ff, lw_addr_in;
   logic [CNT_W-1:0]   lw_data_ff, lw_data_in;
   logic [CNT_W-1:0]   base;
   logic [CNT_W-1:0]   upd_val;

   // scan pipeline: read, scale by 100, accumulate, compare
   logic [P_W-1:0]     p297_ff, p297_in;
   logic [2:0]         sc_val_ff, sc_val_in;
   logic               scan_rd;
   logic [BIN_W-1:0]   sc_i0_ff, sc_i0_in;
   logic [BIN_W-1:0]   sc_i1_ff, sc_i1_in;
   logic [BIN_W-1:0]   sc_i2_ff, sc_i2_in;
   logic [HUND_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               found_ff, found_in;
   logic [BIN_W-1:0]   level_ff, level_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_bin_ff, rsp_bin_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // handshakes
   logic               req_ready;
   logic               req_acc;

   // histogram ram ports
   logic               ram_wr_en;
   logic [BIN_W-1:0]   ram_wr_addr;
   logic [CNT_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [BIN_W-1:0]   ram_rd_addr;
   logic [CNT_W-1:0]   ram_rd_data;

   hpwl_ram #(
      .WIDTH (CNT_W),
      .DEPTH (BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // a new pixel is taken when idle, or while the last write of a pixel
   // that did not end the frame is going back
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FLUSH) && !last_ff);
   assign req_acc   = req_chan.valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      pix_in       = pix_ff;
      sat_in       = sat_ff;
      bin_in       = bin_ff;
      w_val_in     = 1'b0;
      w_addr_in    = w_addr_ff;
      lw_val_in    = 1'b0;
      lw_addr_in   = lw_addr_ff;
      lw_data_in   = lw_data_ff;
      base         = '0;
      upd_val      = '0;
      scan_rd      = 1'b0;
      acc_in       = acc_ff;
      found_in     = found_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_sat_in   = rsp_sat_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      // result taken
      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // write-back: the read issued on the edge of the previous write misses
      // it, so a same-bin hit takes the forwarded value
      if (w_val_ff) begin
         if (lw_val_ff && (lw_addr_ff == w_addr_ff)) begin
            base = lw_data_ff;
         end else begin
            base = ram_rd_data;
         end
         if (base == CNT_MAX) begin
            sat_in  = 1'b1;
            upd_val = base;
         end else begin
            upd_val = base + CNT_W'(1);
         end
         ram_wr_en   = 1'b1;
         ram_wr_addr = w_addr_ff;
         ram_wr_data = upd_val;
         lw_val_in   = 1'b1;
         lw_addr_in  = w_addr_ff;
         lw_data_in  = upd_val;
      end

      // pixel transfer: bin the channels, count the pixel
      if (req_acc) begin
         bin_in[0] = bin_of(req_chan.red);
         bin_in[1] = bin_of(req_chan.green);
         bin_in[2] = bin_of(req_chan.blue);
         last_in   = req_chan.last_pixel;
         if (pix_ff == CNT_MAX) begin
            sat_in = 1'b1;
         end else begin
            pix_in = pix_ff + CNT_W'(1);
         end
         ch_in    = '0;
         state_in = ST_UPD;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = '0;
            cnt_in      = cnt_ff + BIN_W'(1);
            if (cnt_ff == BIN_W'(BINS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_UPD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = bin_ff[ch_ff];
            w_val_in    = 1'b1;
            w_addr_in   = bin_ff[ch_ff];
            ch_in       = ch_ff + 2'd1;
            if (ch_ff == 2'(NUM_CH - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (last_ff) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else if (!req_acc) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // read each bin and zero it behind the read
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = '0;
            scan_rd     = 1'b1;
            cnt_in      = cnt_ff + BIN_W'(1);
            if (cnt_ff == BIN_W'(BINS - 1)) begin
               cnt_in   = '0;
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (sc_val_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = found_ff ? LEVEL_W'(level_ff) : LEVEL_W'(BINS);
               rsp_sat_in   = sat_ff;
               pix_in       = '0;
               sat_in       = 1'b0;
               acc_in       = '0;
               found_in     = 1'b0;
               last_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // scan pipeline; sum > floor(p * 297 / 100) is tested as 100 * sum > p * 297
      if (sc_val_ff[1]) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      if (sc_val_ff[2] && !found_ff && (acc_ff > ACC_W'(p297_ff))) begin
         found_in = 1'b1;
         level_in = sc_i2_ff;
      end
   end

   assign sc_val_in = {sc_val_ff[1:0], scan_rd};
   assign sc_i0_in  = cnt_ff;
   assign sc_i1_in  = sc_i0_ff;
   assign sc_i2_in  = sc_i1_ff;
   assign prod_in   = HUND_W'(ram_rd_data) * HUND_W'(PCT_DEN);
   assign p297_in   = P_W'(pix_ff) * P_W'(CH_PCT);

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      w_addr_ff  <= w_addr_in;
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
      p297_ff    <= p297_in;
      sc_i0_ff   <= sc_i0_in;
      sc_i1_ff   <= sc_i1_in;
      sc_i2_ff   <= sc_i2_in;
      prod_ff    <= prod_in;
      level_ff   <= level_in;
      rsp_bin_ff <= rsp_bin_in;
      rsp_sat_ff <= rsp_sat_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         last_ff      <= 1'b0;
         pix_ff       <= '0;
         sat_ff       <= 1'b0;
         w_val_ff     <= 1'b0;
         lw_val_ff    <= 1'b0;
         sc_val_ff    <= '0;
         acc_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ch_ff        <= ch_in;
         last_ff      <= last_in;
         pix_ff       <= pix_in;
         sat_ff       <= sat_in;
         w_val_ff     <= w_val_in;
         lw_val_ff    <= lw_val_in;
         sc_val_ff    <= sc_val_in;
         acc_ff       <= acc_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.white_bin       = rsp_bin_ff;
   assign rsp_chan.count_saturated = rsp_sat_ff;

endmodule

`default_nettype wire

### rtl/hpwl_checker.sv
// ----------------------------------------------------------------------------
// hpwl_checker
// port-level assertions on the white level core
// ----------------------------------------------------------------------------
`default_nettype none

module hpwl_checker import hpwl_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               req_last_pixel,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [LEVEL_W-1:0] rsp_white_bin,
   input wire logic               rsp_count_saturated
);

   // a held result stays until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_white_bin) && $stable(rsp_count_saturated))
      else $error("result payload changed while stalled");

   // the zeroing pass follows reset: no transfer taken, no result shown
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("core active straight after reset");

   // a frame end starts the histogram update and scan
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_pixel |=> !req_ready)
      else $error("pixel taken right after frame end");

endmodule

bind histogram_percentile_white_level_core hpwl_checker u_hpwl_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_last_pixel      (req_chan.last_pixel),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_white_bin       (rsp_chan.white_bin),
   .rsp_count_saturated (rsp_chan.count_saturated)
);

`default_nettype wire

### tb/histogram_percentile_white_level_core_test.sv
// ----------------------------------------------------------------------------
// histogram_percentile_white_level_core_test
// self-checking bench for the rgb histogram white level core
//
// pixels are sent in bursts with random gaps and result transfers are stalled
// at random. every accepted pixel updates a local copy of the histogram, and
// each frame end turns it into the expected 99th percentile bin. results are
// checked field by field in order of arrival. directed frames come first,
// then random frames of varied length and tonal spread
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module histogram_percentile_white_level_core_test;
   import hpwl_pkg::*;

   localparam int BINS          = BINS_DEFAULT;
   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 3;
   localparam int RANDOM_PIXELS = 1550;
   localparam int MAX_GAP       = 12;      // longest sender pause
   localparam int MAX_STALL     = 40;      // longest receiver stall
   // worst quiet spell: scan of a frame end, a full receiver stall, a sender
   // pause and a pixel's own passes; the same figure covers the zeroing pass
   localparam int QUIET_LIMIT   = 8 * (BINS + MAX_STALL + MAX_GAP + 16);
   localparam int DRAIN_CYCLES  = BINS + 16;
   localparam int SHOWN_ERRORS  = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_pixel;
   } pixel_t;

   typedef struct packed {
      logic [LEVEL_W-1:0] white_bin;
      logic               count_saturated;
   } level_t;

   // tonal spread of a random frame
   typedef enum int {
      TONE_UNIFORM,
      TONE_DARK,
      TONE_BRIGHT,
      TONE_CLUSTER,
      TONE_EXTREME
   } tone_t;

   logic clock = 1'b0;
   logic reset;

   hpwl_req_if req_chan ();
   hpwl_rsp_if rsp_chan ();

   histogram_percentile_white_level_core #(
      .BINS (BINS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // local copy of the frame histogram
   // ---------------------------------------------------------------------------
   logic [CNT_W-1:0] hist_count [BINS];
   logic [CNT_W-1:0] frame_pixels;
   bit               frame_saturated;

   // levels still owed by the core, oldest first
   level_t expected_levels [$];

   int unsigned error_count;
   int unsigned quiet_cycles;
   int unsigned burst_left;
   int unsigned stall_left;
   int unsigned stall_phase_left;
   bit          stall_choppy;
   level_t      oldest_level;

   function automatic int unsigned channel_bin(logic [CHAN_W-1:0] value);
      longint unsigned scaled;
      scaled = (64'(value) * 64'(BINS)) / 64'(BYTE_MAX);
      // full scale lands one past the top bin
      if (scaled > 64'(BINS - 1))
         scaled = 64'(BINS - 1);
      return int'(scaled);
   endfunction

   function automatic void tally_channel(logic [CHAN_W-1:0] value);
      int unsigned slot;
      slot = channel_bin(value);
      if (hist_count[slot] == CNT_MAX)
         frame_saturated = 1'b1;
      else
         hist_count[slot] = hist_count[slot] + 1'b1;
   endfunction

   // first bin whose running total passes 3 * pixels * 99 / 100
   function automatic logic [LEVEL_W-1:0] percentile_bin();
      longint unsigned threshold;
      longint unsigned running;
      threshold = (64'(frame_pixels) * 64'(NUM_CH) * 64'(PCT_NUM)) / 64'(PCT_DEN);
      running   = 0;
      for (int i = 0; i < BINS; i++) begin
         running += 64'(hist_count[i]);
         if (running > threshold)
            return LEVEL_W'(i);
      end
      // nothing qualifies: full scale
      return LEVEL_W'(BINS);
   endfunction

   function automatic void clear_frame();
      for (int i = 0; i < BINS; i++)
         hist_count[i] = '0;
      frame_pixels    = '0;
      frame_saturated = 1'b0;
   endfunction

   // the last pixel is counted before the level is taken
   function automatic void tally_pixel(pixel_t px);
      level_t level;
      tally_channel(px.red);
      tally_channel(px.green);
      tally_channel(px.blue);
      if (frame_pixels == CNT_MAX)
         frame_saturated = 1'b1;
      else
         frame_pixels = frame_pixels + 1'b1;
      if (px.last_pixel) begin
         level.white_bin       = percentile_bin();
         level.count_saturated = frame_saturated;
         expected_levels.push_back(level);
         clear_frame();
      end
   endfunction

   function automatic void note_error(string text);
      error_count++;
      if (error_count <= SHOWN_ERRORS)
         $display("%0t: %s", $realtime, text);
   endfunction

   // ---------------------------------------------------------------------------
   // pixel sender: bursts of random length with random pauses between them
   // ---------------------------------------------------------------------------
   task automatic send_pixel(input pixel_t px);
      int unsigned gap;
      if (burst_left == 0) begin
         // a third of the bursts follow straight on
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.red        <= px.red;
      req_chan.green      <= px.green;
      req_chan.blue       <= px.blue;
      req_chan.last_pixel <= px.last_pixel;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      tally_pixel(px);
   endtask

   function automatic pixel_t make_pixel(int unsigned r, int unsigned g, int unsigned b,
                                         bit last);
      pixel_t px;
      px.red        = CHAN_W'(r);
      px.green      = CHAN_W'(g);
      px.blue       = CHAN_W'(b);
      px.last_pixel = last;
      return px;
   endfunction

   function automatic logic [CHAN_W-1:0] pick_byte(tone_t tone, int unsigned centre);
      int unsigned lo;
      int unsigned hi;
      lo = (centre < 6) ? 0 : centre - 6;
      hi = (centre > BYTE_MAX - 6) ? BYTE_MAX : centre + 6;
      case (tone)
         TONE_DARK:    return CHAN_W'($urandom_range(0, 31));
         TONE_BRIGHT:  return CHAN_W'($urandom_range(BYTE_MAX - 31, BYTE_MAX));
         TONE_CLUSTER: return CHAN_W'($urandom_range(lo, hi));
         TONE_EXTREME: return $urandom_range(0, 1) ? CHAN_W'(BYTE_MAX) : '0;
         default:      return CHAN_W'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // one pixel per frame: the level is the bin of the brightest channel
   task automatic test_single_pixel_frames();
      send_pixel(make_pixel(0,   0,   0,   1));
      send_pixel(make_pixel(255, 255, 255, 1));
      send_pixel(make_pixel(0,   128, 255, 1));
      send_pixel(make_pixel(255, 0,   0,   1));
      send_pixel(make_pixel(254, 254, 254, 1));
      send_pixel(make_pixel(1,   2,   3,   1));
   endtask

   // a few pixels each, brightest value in different channels and positions
   task automatic test_short_frames();
      send_pixel(make_pixel(10,  20,  30,  0));
      send_pixel(make_pixel(40,  50,  60,  0));
      send_pixel(make_pixel(200, 100, 0,   1));

      send_pixel(make_pixel(170, 85,  255, 0));
      send_pixel(make_pixel(85,  170, 0,   0));
      send_pixel(make_pixel(170, 85,  255, 0));
      send_pixel(make_pixel(85,  170, 0,   1));

      // full scale in one channel of the final pixel only
      send_pixel(make_pixel(0,   0,   0,   0));
      send_pixel(make_pixel(0,   0,   0,   0));
      send_pixel(make_pixel(0,   0,   255, 1));
   endtask

   // frame ends back to back, so a level can wait on the one before it
   task automatic test_frame_end_bursts();
      send_pixel(make_pixel(128, 64,  32,  1));
      send_pixel(make_pixel(15,  240, 85,  1));
      send_pixel(make_pixel(170, 1,   254, 1));
      send_pixel(make_pixel(127, 128, 129, 1));
   endtask

   // random frames: mostly short, some medium, a few long enough to move the
   // percentile below the brightest counts
   task automatic test_random_frames(input int unsigned pixel_budget);
      int unsigned sent;
      int unsigned frame_len;
      int unsigned pick;
      int unsigned centre;
      tone_t       tone;
      sent = 0;
      while (sent < pixel_budget) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            frame_len = $urandom_range(1, 12);
         else if (pick < 19)
            frame_len = $urandom_range(13, 90);
         else
            frame_len = $urandom_range(150, 400);
         tone   = tone_t'($urandom_range(TONE_UNIFORM, TONE_EXTREME));
         centre = $urandom_range(0, BYTE_MAX);
         for (int n = 0; n < frame_len; n++) begin
            send_pixel(make_pixel(pick_byte(tone, centre), pick_byte(tone, centre),
                                  pick_byte(tone, centre), n == frame_len - 1));
         end
         sent += frame_len;
      end
   endtask

   // ---------------------------------------------------------------------------
   // result receiver: spells of free flow and spells of random stalls
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_choppy     = $urandom_range(0, 2) != 0;
         stall_phase_left = $urandom_range(20, 300);
      end else begin
         stall_phase_left--;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_choppy && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, MAX_STALL);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // level checker: each result transfer against the oldest expected level
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_levels.size() == 0) begin
            note_error($sformatf("level %0d sat %0b with no frame end pending",
                                 rsp_chan.white_bin, rsp_chan.count_saturated));
         end else begin
            oldest_level = expected_levels.pop_front();
            if (rsp_chan.white_bin !== oldest_level.white_bin)
               note_error($sformatf("white_bin expected %0d got %0d",
                                    oldest_level.white_bin, rsp_chan.white_bin));
            if (rsp_chan.count_saturated !== oldest_level.count_saturated)
               note_error($sformatf("count_saturated expected %0b got %0b",
                                    oldest_level.count_saturated,
                                    rsp_chan.count_saturated));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long without any transfer on either channel
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d levels outstanding",
                  $realtime, quiet_cycles, expected_levels.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.red        = '0;
      req_chan.green      = '0;
      req_chan.blue       = '0;
      req_chan.last_pixel = 1'b0;
      rsp_chan.ready      = 1'b0;
      error_count         = 0;
      quiet_cycles        = 0;
      burst_left          = 0;
      stall_left          = 0;
      stall_phase_left    = 0;
      clear_frame();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // the core's zeroing pass simply holds off the first transfer
      test_single_pixel_frames();
      test_short_frames();
      test_frame_end_bursts();
      test_random_frames(RANDOM_PIXELS);
      req_chan.valid <= 1'b0;

      while (expected_levels.size() != 0)
         @(posedge clock);
      // room for any stray level after the last scan
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_levels.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
